### design/abrf_pkg.sv
// ----------------------------------------------------------------------------
// abrf_pkg
// Shared types and constants for the alpha-beta range filter.
// ----------------------------------------------------------------------------
package abrf_pkg;

  // fixed-point format of the estimates and gains
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned GAIN_WIDTH = 16;

  // gain reset values, Q0.16 (about 0.1 and 0.01)
  localparam logic [GAIN_WIDTH-1:0] ALPHA_RESET = 16'd6554;
  localparam logic [GAIN_WIDTH-1:0] BETA_RESET  = 16'd655;

  // configuration register indexes
  localparam int unsigned REG_IDX_WIDTH = 2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ALPHA = 2'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BETA  = 2'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MIN   = 2'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MAX   = 2'd3;

  // filter gains as handed to the core
  typedef struct packed {
    logic [GAIN_WIDTH-1:0] alpha;
    logic [GAIN_WIDTH-1:0] beta;
  } gains_t;

  // shared adder operation
  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,   // waiting for a sample
    ST_DT,     // elapsed time
    ST_MAG,    // magnitude of the rate
    ST_MUL,    // |rate| * dt, one dt bit per cycle
    ST_PROD,   // sign and saturation of the product
    ST_PRED,   // predicted position
    ST_RES,    // residual
    ST_GA,     // alpha * residual, one gain bit per cycle
    ST_RNDA,   // round the alpha term
    ST_CORR,   // corrected position
    ST_GB,     // beta * residual, one gain bit per cycle
    ST_RNDB,   // round the beta term
    ST_BMAG,   // magnitude of the beta term
    ST_NUM,    // add half of dt for rounding
    ST_DIV,    // restoring division by dt, one quotient bit per cycle
    ST_RATE,   // rate update
    ST_YRND,   // round the position to the sample format
    ST_EMIT    // window test and result hand-off
  } seq_state_t;

endpackage

### design/abrf_addsub.sv
// ----------------------------------------------------------------------------
// abrf_addsub
// Shared signed adder/subtractor used by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module abrf_addsub
  import abrf_pkg::*;
#(
  parameter int unsigned WIDTH = 57
) (
  input  alu_op_t                  op,
  input  logic signed [WIDTH-1:0]  op_a,
  input  logic signed [WIDTH-1:0]  op_b,
  output logic signed [WIDTH-1:0]  sum
);

  // one wide add or subtract
  always_comb begin
    unique case (op)
      ALU_ADD: sum = op_a + op_b;
      ALU_SUB: sum = op_a - op_b;
    endcase
  end

endmodule

### design/abrf_core.sv
// ----------------------------------------------------------------------------
// abrf_core
// Sequencer and state registers of the filter; every add and subtract of the
// estimates is done by one shared adder, including shift-add multiplies and a restoring divider.
// ----------------------------------------------------------------------------
module abrf_core
  import abrf_pkg::*;
#(
  parameter int unsigned RANGE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // sample in
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RANGE_WIDTH-1:0]  in_range,
  input  logic [TIME_WIDTH-1:0]   in_time,
  // configuration
  input  gains_t                  gains,
  input  logic [RANGE_WIDTH-1:0]  win_lo,
  input  logic [RANGE_WIDTH-1:0]  win_hi,
  // result out
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [RANGE_WIDTH-1:0]  res_range
);

  // widths
  localparam int unsigned SW   = RANGE_WIDTH + 24;                        // state
  localparam int unsigned DW   = (SW + 17 > TIME_WIDTH + 2) ? SW + 17 : TIME_WIDTH + 2;
  localparam int unsigned QW   = ((SW > TIME_WIDTH) ? SW : TIME_WIDTH) + 1; // dividend
  localparam int unsigned YW   = SW + 1 - FRAC_BITS;                      // rounded pos
  localparam int unsigned CNTW = $clog2(QW);
  localparam int unsigned TIDX = $clog2(TIME_WIDTH);
  localparam int unsigned GIDX = $clog2(GAIN_WIDTH);

  localparam logic signed [DW-1:0] D_MAX = {{(DW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [DW-1:0] D_MIN = ~D_MAX;
  localparam logic signed [DW-1:0] HALF  =
    {{(DW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // clamp a wide sum to the signed state range
  function automatic logic signed [SW-1:0] sat(input logic signed [DW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > D_MAX)      r = D_MAX[SW-1:0];
    else if (v < D_MIN) r = D_MIN[SW-1:0];
    else                r = v[SW-1:0];
    return r;
  endfunction

  seq_state_t state, state_next;

  logic [CNTW-1:0]         cnt;
  logic [RANGE_WIDTH-1:0]  meas;
  logic [TIME_WIDTH-1:0]   t_in;
  logic signed [SW-1:0]    pos;
  logic signed [SW-1:0]    rate;
  logic [TIME_WIDTH-1:0]   last;
  logic [TIME_WIDTH-1:0]   dt;
  logic [SW-1:0]           mag;
  logic                    ovf;
  logic                    neg;
  logic signed [DW-1:0]    acc;
  logic signed [SW-1:0]    pred;
  logic signed [SW:0]      resid;
  logic [QW-1:0]           num;
  logic [TIME_WIDTH-1:0]   rem;
  logic signed [YW-1:0]    y;

  // shared adder
  alu_op_t              op;
  logic signed [DW-1:0] op_a;
  logic signed [DW-1:0] op_b;
  logic signed [DW-1:0] sum;

  abrf_addsub #(.WIDTH(DW)) u_addsub (
    .op   (op),
    .op_a (op_a),
    .op_b (op_b),
    .sum  (sum)
  );

  logic [TIME_WIDTH:0]    div_shift;
  logic [YW-2:0]          y_mag;
  logic                   in_win;
  logic                   accept;

  assign accept    = in_valid && in_ready;
  assign div_shift = {rem, num[QW-1]};
  assign y_mag     = y[YW-2:0];
  assign in_win    = !y[YW-1] && (y_mag >= (YW-1)'(win_lo))
                     && (y_mag <= (YW-1)'(win_hi));
  assign res_range = y[RANGE_WIDTH-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, handshakes and adder operands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    op         = ALU_ADD;
    op_a       = '0;
    op_b       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_DT;
      end
      ST_DT: begin
        op         = ALU_SUB;
        op_a       = {{(DW-TIME_WIDTH){1'b0}}, t_in};
        op_b       = {{(DW-TIME_WIDTH){1'b0}}, last};
        state_next = ST_MAG;
      end
      ST_MAG: begin
        op         = rate[SW-1] ? ALU_SUB : ALU_ADD;
        op_b       = {{(DW-SW){rate[SW-1]}}, rate};
        state_next = ST_MUL;
      end
      ST_MUL: begin
        op_a = acc <<< 1;
        op_b = dt[cnt[TIDX-1:0]] ? {{(DW-SW){1'b0}}, mag} : '0;
        if (cnt == '0) state_next = ST_PROD;
      end
      ST_PROD: begin
        op         = neg ? ALU_SUB : ALU_ADD;
        op_b       = acc;
        state_next = ST_PRED;
      end
      ST_PRED: begin
        op_a       = {{(DW-SW){pos[SW-1]}}, pos};
        op_b       = acc;
        state_next = ST_RES;
      end
      ST_RES: begin
        op         = ALU_SUB;
        op_a       = {{(DW-RANGE_WIDTH-FRAC_BITS){1'b0}}, meas, {FRAC_BITS{1'b0}}};
        op_b       = {{(DW-SW){pred[SW-1]}}, pred};
        state_next = ST_GA;
      end
      ST_GA, ST_GB: begin
        op_a = acc <<< 1;
        if ((state == ST_GA) ? gains.alpha[cnt[GIDX-1:0]] : gains.beta[cnt[GIDX-1:0]])
          op_b = {{(DW-SW-1){resid[SW]}}, resid};
        if (cnt == '0) state_next = (state == ST_GA) ? ST_RNDA : ST_RNDB;
      end
      ST_RNDA: begin
        op_a       = acc;
        op_b       = HALF;
        state_next = ST_CORR;
      end
      ST_CORR: begin
        op_a       = {{(DW-SW){pred[SW-1]}}, pred};
        op_b       = acc;
        state_next = (dt == '0) ? ST_YRND : ST_GB;
      end
      ST_RNDB: begin
        op_a       = acc;
        op_b       = HALF;
        state_next = ST_BMAG;
      end
      ST_BMAG: begin
        op         = acc[DW-1] ? ALU_SUB : ALU_ADD;
        op_b       = acc;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        op_a       = {{(DW-QW){1'b0}}, num};
        op_b       = {{(DW-TIME_WIDTH){1'b0}}, 1'b0, dt[TIME_WIDTH-1:1]};
        state_next = ST_DIV;
      end
      ST_DIV: begin
        op   = ALU_SUB;
        op_a = {{(DW-TIME_WIDTH-1){1'b0}}, div_shift};
        op_b = {{(DW-TIME_WIDTH){1'b0}}, dt};
        if (cnt == '0) state_next = ST_RATE;
      end
      ST_RATE: begin
        op         = neg ? ALU_SUB : ALU_ADD;
        op_a       = {{(DW-SW){rate[SW-1]}}, rate};
        op_b       = {{(DW-QW){1'b0}}, num};
        state_next = ST_YRND;
      end
      ST_YRND: begin
        op_a       = {{(DW-SW){pos[SW-1]}}, pos};
        op_b       = HALF;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        res_valid = in_win;
        if (!in_win || res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // filter state: cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      rate <= '0;
      last <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          // seed the position when both estimates are zero
          if (accept && pos == '0 && rate == '0)
            pos <= {{(SW-RANGE_WIDTH-FRAC_BITS){1'b0}}, in_range, {FRAC_BITS{1'b0}}};
        end
        ST_DT:   last <= t_in;
        ST_CORR: pos  <= sat(sum);
        ST_RATE: rate <= sat(sum);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        meas <= in_range;
        t_in <= in_time;
      end
      ST_DT: begin
        dt  <= sum[TIME_WIDTH-1:0];
        neg <= rate[SW-1];
      end
      ST_MAG: begin
        mag <= sum[SW-1:0];
        acc <= '0;
        ovf <= 1'b0;
        cnt <= CNTW'(TIME_WIDTH - 1);
      end
      ST_MUL: begin
        // sticky overflow: the product only grows from here
        if (!ovf) begin
          if (sum > D_MAX) ovf <= 1'b1;
          else             acc <= sum;
        end
        cnt <= cnt - 1'b1;
      end
      ST_PROD: acc  <= ovf ? (neg ? D_MIN : D_MAX) : sum;
      ST_PRED: pred <= sat(sum);
      ST_RES: begin
        resid <= sum[SW:0];
        acc   <= '0;
        cnt   <= CNTW'(GAIN_WIDTH - 1);
      end
      ST_GA, ST_GB: begin
        acc <= sum;
        cnt <= cnt - 1'b1;
      end
      ST_RNDA, ST_RNDB: acc <= sum >>> FRAC_BITS;
      ST_CORR: begin
        acc <= '0;
        cnt <= CNTW'(GAIN_WIDTH - 1);
      end
      ST_BMAG: begin
        neg <= acc[DW-1];
        num <= sum[QW-1:0];
      end
      ST_NUM: begin
        num <= sum[QW-1:0];
        rem <= '0;
        cnt <= CNTW'(QW - 1);
      end
      ST_DIV: begin
        // trial subtract of the divisor, quotient bit shifts in at the bottom
        if (!sum[DW-1]) rem <= sum[TIME_WIDTH-1:0];
        else            rem <= div_shift[TIME_WIDTH-1:0];
        num <= {num[QW-2:0], ~sum[DW-1]};
        cnt <= cnt - 1'b1;
      end
      ST_YRND: y <= sum[SW:FRAC_BITS];
      default: ;
    endcase
  end

  // a sample keeps the core busy: it is not ready right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("core ready again right after taking a sample");

  // only values inside the window leave the core
  a_result_in_window: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_range >= win_lo) && (res_range <= win_hi))
    else $error("result outside the range window");

  // divider remainder stays below the divisor
  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < dt))
    else $error("divider remainder not below dt");

endmodule

### design/alpha_beta_range_filter.sv
// ----------------------------------------------------------------------------
// alpha_beta_range_filter
// Fixed-point alpha-beta filter for timestamped range samples, with a range
// window on the output.
//
//  Channel  Signals                     Dir  Beat contents
//  s_*      s_tvalid s_tready s_tdata   in   measured_range, sample_time
//  m_*      m_tvalid m_tready m_tdata   out  est_range
//  cfg_*    cfg_we cfg_addr cfg_wdata   in   alpha, beta, min, max (index 0..3)
//
// A sample is worked through on the shared adder, one dt bit per cycle for
// the prediction, one gain bit per cycle for each correction and one quotient
// bit per cycle for the rate division; the rate update is skipped when the
// elapsed time is zero. s_tready is high only while the core is idle, so a
// new sample is taken only once the last one is through. A held output beat
// stalls the core in its last step until the output register frees. rst
// clears the estimates, the timestamp, the configuration registers and the
// output valid flag.
// ----------------------------------------------------------------------------
module alpha_beta_range_filter
  import abrf_pkg::*;
#(
  parameter int unsigned RANGE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // sample stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [((RANGE_WIDTH+TIME_WIDTH+7)/8)*8-1:0] s_tdata, // measured_range, sample_time
  // filtered stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [((RANGE_WIDTH+7)/8)*8-1:0] m_tdata,            // est_range
  // configuration writes
  input  logic                    cfg_we,
  input  logic [REG_IDX_WIDTH-1:0] cfg_addr,
  input  logic [((RANGE_WIDTH > GAIN_WIDTH) ? RANGE_WIDTH : GAIN_WIDTH)-1:0] cfg_wdata
);

  localparam int unsigned OUT_W = ((RANGE_WIDTH + 7) / 8) * 8;

  gains_t                 gains;
  logic [RANGE_WIDTH-1:0] win_lo;
  logic [RANGE_WIDTH-1:0] win_hi;

  logic                   res_valid;
  logic                   res_ready;
  logic [RANGE_WIDTH-1:0] res_range;
  logic [RANGE_WIDTH-1:0] out_range;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.alpha <= ALPHA_RESET;
      gains.beta  <= BETA_RESET;
      win_lo      <= '0;
      win_hi      <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ALPHA: gains.alpha <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_BETA:  gains.beta  <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_MIN:   win_lo      <= cfg_wdata[RANGE_WIDTH-1:0];
        REG_MAX:   win_hi      <= cfg_wdata[RANGE_WIDTH-1:0];
      endcase
    end
  end

  abrf_core #(
    .RANGE_WIDTH (RANGE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_range  (s_tdata[RANGE_WIDTH-1:0]),
    .in_time   (s_tdata[RANGE_WIDTH+TIME_WIDTH-1:RANGE_WIDTH]),
    .gains     (gains),
    .win_lo    (win_lo),
    .win_hi    (win_hi),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_range (res_range)
  );

  // output register: takes a result whenever the slot is empty or draining
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_range <= res_range;
  end

  assign m_tdata = OUT_W'(out_range);

endmodule

### verif/alpha_beta_range_filter_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_beta_range_filter_check
// Watches the sample, filtered and configuration ports of the range filter.
// It keeps its own copy of the filter state and gains, works out the filtered
// range that each accepted sample should give, and compares every filtered
// beat with the oldest outstanding value.
// ----------------------------------------------------------------------------
module alpha_beta_range_filter_check
  import abrf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [47:0]              s_tdata,     // measured_range, sample_time
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [15:0]              m_tdata,     // est_range
  input  logic                     cfg_we,
  input  logic [REG_IDX_WIDTH-1:0] cfg_addr,
  input  logic [15:0]              cfg_wdata,
  output int                       mismatch_count,
  output int                       results_due
);

  // estimates carry 40 signed bits with 16 fraction bits
  localparam longint EST_MAX = (64'sd1 <<< 39) - 64'sd1;
  localparam longint EST_MIN = -EST_MAX - 64'sd1;

  logic [15:0] alpha_q, beta_q, win_lo, win_hi;
  longint      pos_est, rate_est;
  logic [31:0] prev_time;
  logic [15:0] filtered_due[$];
  int          fails = 0;

  assign mismatch_count = fails;

  function automatic longint clip_est(input longint v);
    if (v > EST_MAX) return EST_MAX;
    if (v < EST_MIN) return EST_MIN;
    return v;
  endfunction

  // round(g * r / 2^16), ties towards plus infinity
  function automatic longint apply_gain(input logic [15:0] g, input longint r);
    longint gs;
    gs = g;
    return (gs * r + 64'sd32768) >>> 16;
  endfunction

  // round(v / d), ties away from zero, d > 0
  function automatic longint div_nearest(input longint v, input longint d);
    longint m, q;
    m = (v < 0) ? -v : v;
    q = (m + d / 2) / d;
    return (v < 0) ? -q : q;
  endfunction

  // one filter update; returns 1 when the corrected range falls in the window
  function automatic bit track_estimate(input logic [15:0] meas, input logic [31:0] stamp,
                                        output logic [15:0] range_out);
    longint      meas_fx, dt, mag, prod, pred, resid, corr, rnd, lo, hi;
    logic [31:0] dt32;
    meas_fx = meas;
    meas_fx = meas_fx <<< 16;
    range_out = '0;
    if (pos_est == 0 && rate_est == 0) pos_est = meas_fx;

    dt32 = stamp - prev_time;
    dt = dt32;
    prev_time = stamp;

    // prediction, with the rate product saturated
    mag = (rate_est < 0) ? -rate_est : rate_est;
    if (dt != 0 && mag > EST_MAX / dt)
      prod = (rate_est < 0) ? EST_MIN : EST_MAX;
    else
      prod = (rate_est < 0) ? -(mag * dt) : mag * dt;
    pred = clip_est(pos_est + prod);

    // correction
    resid = meas_fx - pred;
    corr = clip_est(pred + apply_gain(alpha_q, resid));
    pos_est = corr;
    if (dt != 0)
      rate_est = clip_est(rate_est + div_nearest(apply_gain(beta_q, resid), dt));

    // window test on the rounded position
    rnd = (corr + 64'sd32768) >>> 16;
    lo = win_lo;
    hi = win_hi;
    if (rnd < lo || rnd > hi) return 0;
    if (rnd < 0) rnd = 0;
    if (rnd > 65535) rnd = 65535;
    range_out = rnd[15:0];
    return 1;
  endfunction

  task automatic report_bad(input string what, input logic [15:0] want,
                            input logic [15:0] got);
    if (fails < 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    fails++;
  endtask

  // predict on accepted samples, compare on accepted filtered beats
  always @(posedge clk) begin : watch
    logic [15:0] range_exp;
    logic [15:0] head;
    bit          emitted;
    if (rst) begin
      alpha_q   = ALPHA_RESET;
      beta_q    = BETA_RESET;
      win_lo    = 16'd0;
      win_hi    = 16'hFFFF;
      pos_est   = 0;
      rate_est  = 0;
      prev_time = '0;
      filtered_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ALPHA: alpha_q = cfg_wdata;
          REG_BETA:  beta_q  = cfg_wdata;
          REG_MIN:   win_lo  = cfg_wdata;
          REG_MAX:   win_hi  = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        emitted = track_estimate(s_tdata[15:0], s_tdata[47:16], range_exp);
        if (emitted) filtered_due.push_back(range_exp);
      end
      if (m_tvalid && m_tready) begin
        if (filtered_due.size() == 0) begin
          report_bad("filtered beat with nothing outstanding", 16'd0, m_tdata);
        end else begin
          head = filtered_due.pop_front();
          if (m_tdata !== head) report_bad("est_range mismatch", head, m_tdata);
        end
      end
    end
    results_due <= filtered_due.size();
  end

endmodule

### verif/alpha_beta_range_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_beta_range_filter_tb
// Drives timestamped range samples and gain/window settings into the range
// filter: a short directed run over the edge cases, then tracked targets with
// noise under several settings, with random idling on both streams. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module alpha_beta_range_filter_tb;
  import abrf_pkg::*;

  localparam int     BUSY_CYCLES = 160;          // one sample at most, with margin
  localparam int     PHASES      = 9;
  localparam int     PHASE_ITEMS = 200;
  localparam longint LIMIT_NS    = 64'd25_000_000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [47:0]              s_tdata;    // measured_range, sample_time
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [15:0]              m_tdata;    // est_range
  logic                     cfg_we;
  logic [REG_IDX_WIDTH-1:0] cfg_addr;
  logic [15:0]              cfg_wdata;

  int          mismatch_count;
  int          results_due;
  int          tx_gap_pct   = 0;
  int          rx_stall_pct = 0;
  bit          quiet        = 1'b0;
  int          stall_left   = 0;
  int          track_pos    = 20000;
  int          track_vel    = 40;
  logic [31:0] clock_us     = '0;

  always #5 clk = ~clk;

  alpha_beta_range_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  alpha_beta_range_filter_check check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      stall_left <= $urandom_range(1, 8);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one sample beat; valid stays high on return
  task automatic push_sample(input logic [15:0] range_val, input logic [31:0] stamp);
    if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, 16'($urandom)};
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp, range_val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding filtered beat
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // write all four registers once the core has gone quiet
  task automatic set_filter(input logic [15:0] alpha, input logic [15:0] beta,
                            input logic [15:0] lo, input logic [15:0] hi);
    drain();
    repeat (BUSY_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ALPHA;
    cfg_wdata <= alpha;
    @(posedge clk);
    cfg_addr  <= REG_BETA;
    cfg_wdata <= beta;
    @(posedge clk);
    cfg_addr  <= REG_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr  <= REG_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // well-formed sample: a moving target seen with noise at a plausible rate
  task automatic track_sample();
    int          sel;
    int          meas;
    logic [31:0] step;
    sel = $urandom_range(0, 99);
    if (sel < 4)       step = '0;
    else if (sel < 12) step = $urandom_range(1, 200);
    else               step = $urandom_range(5000, 100000);
    clock_us = clock_us + step;
    if ($urandom_range(0, 29) == 0) track_vel = int'($urandom_range(0, 800)) - 400;
    track_pos = track_pos + track_vel;
    if (track_pos < 0) begin
      track_pos = -track_pos;
      track_vel = -track_vel;
    end
    if (track_pos > 65535) begin
      track_pos = 131070 - track_pos;
      track_vel = -track_vel;
    end
    meas = track_pos + int'($urandom_range(0, 96)) - 48;
    if (meas < 0) meas = 0;
    if (meas > 65535) meas = 65535;
    push_sample(meas[15:0], clock_us);
  endtask

  // outlier: any range, and a jumped, repeated or stepped timestamp
  task automatic noise_sample();
    case ($urandom_range(0, 3))
      0:       clock_us = $urandom;
      1:       ;
      default: clock_us = clock_us + $urandom_range(1, 1 << 20);
    endcase
    push_sample(16'($urandom_range(0, 65535)), clock_us);
  endtask

  function automatic logic [15:0] pick_gain(input logic [15:0] dflt);
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return dflt;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    logic [15:0] lo, hi, alpha, beta;
    int          span;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_ALPHA;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset gains: seeding, zero dt, range extremes, timestamp wrap
    push_sample(16'd1600, 32'd20000);
    push_sample(16'd1700, 32'd20000);
    push_sample(16'd1800, 32'd40000);
    push_sample(16'd0, 32'd60000);
    push_sample(16'hFFFF, 32'd80000);
    push_sample(16'hFFFF, 32'hFFFF_FFF0);
    push_sample(16'd30000, 32'h0000_0010);
    push_sample(16'd30000, 32'hFFFF_FFFF);

    // full gains: large rate swings and a saturated prediction
    set_filter(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    push_sample(16'd100, 32'd0);
    push_sample(16'd60000, 32'd1);
    push_sample(16'd60000, 32'd1);
    push_sample(16'd0, 32'd2);
    push_sample(16'd0, 32'h8000_0000);

    // zero gains inside a narrow window
    set_filter(16'd0, 16'd0, 16'd1600, 16'd32000);
    push_sample(16'd5000, 32'h8000_1000);
    push_sample(16'd5100, 32'h8000_2000);
    push_sample(16'd40000, 32'h8000_3000);
    push_sample(16'd1000, 32'h8000_4000);

    // crossed window: nothing may come out
    set_filter(ALPHA_RESET, BETA_RESET, 16'hFFFF, 16'd0);
    push_sample(16'd20000, 32'h9000_0000);
    push_sample(16'd20100, 32'h9000_8000);
    push_sample(16'd0, 32'h9001_0000);

    // random phases; the last one runs without idling
    clock_us  = 32'hFFF0_0000;
    track_pos = 20000;
    for (int p = 0; p < PHASES; p++) begin
      alpha = pick_gain(ALPHA_RESET);
      beta  = pick_gain(BETA_RESET);
      case ($urandom_range(0, 3))
        0, 1: begin
          lo = 16'd0;
          hi = 16'hFFFF;
        end
        2: begin
          lo   = 16'($urandom_range(0, 30000));
          span = $urandom_range(0, 35535);
          hi   = lo + 16'(span);
        end
        default: begin
          lo = 16'($urandom_range(1, 20000));
          hi = 16'($urandom_range(40000, 65534));
        end
      endcase
      if (p == PHASES - 1) begin
        alpha = ALPHA_RESET;
        beta  = BETA_RESET;
        lo    = 16'd0;
        hi    = 16'hFFFF;
      end
      set_filter(alpha, beta, lo, hi);
      if (p == PHASES - 1) quiet = 1'b1;
      case ($urandom_range(0, 2))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 20;
        default: tx_gap_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0:       rx_stall_pct = 0;
        1:       rx_stall_pct = 5;
        2:       rx_stall_pct = 20;
        default: rx_stall_pct = 50;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 80) track_sample();
        else noise_sample();
        if (!quiet && $urandom_range(0, 149) == 0) drain();
      end
    end

    // let the last results out
    drain();
    repeat (BUSY_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("alpha_beta_range_filter_tb: PASS");
    else
      $display("alpha_beta_range_filter_tb: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("alpha_beta_range_filter_tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
design/abrf_pkg.sv
design/abrf_addsub.sv
design/abrf_core.sv
design/alpha_beta_range_filter.sv
verif/alpha_beta_range_filter_check.sv
verif/alpha_beta_range_filter_tb.sv
